// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted during reset.
`define ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication, muted during reset.
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// ===== rtl/i2cms_pkg.sv =====
package i2cms_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam int BITS_PER_BYTE = 8;
  localparam int SEGS_PER_BIT  = 3;
  localparam int BIT_SEGS      = BITS_PER_BYTE * SEGS_PER_BIT;

  localparam logic [4:0] LAST_STEP_COND = 5'd3;
  localparam logic [4:0] LAST_STEP_BYTE = 5'(BIT_SEGS + 5);

  // write: data bits, then idle, release, ack sample
  localparam logic [4:0] WR_BITS_END = 5'(BIT_SEGS);
  localparam logic [4:0] WR_REL_SCL  = 5'(BIT_SEGS + 1);
  localparam logic [4:0] WR_REL_SDA  = 5'(BIT_SEGS + 2);
  localparam logic [4:0] WR_ACK_HI   = 5'(BIT_SEGS + 3);
  localparam logic [4:0] WR_ACK_SMP  = 5'(BIT_SEGS + 4);

  // read: release, data samples, ack bit, closing low
  localparam logic [4:0] RD_BITS_BEG = 5'd2;
  localparam logic [4:0] RD_BITS_END = 5'(BIT_SEGS + 2);
  localparam logic [4:0] RD_ACK_SDA  = 5'(BIT_SEGS + 3);
  localparam logic [4:0] RD_ACK_HI   = 5'(BIT_SEGS + 4);

  localparam logic [1:0] PH_LOW  = 2'd0;
  localparam logic [1:0] PH_MID  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  localparam logic [2:0] BIT_TOP = 3'(BITS_PER_BYTE - 1);

  localparam logic [15:0] UNIT_DELAY_RST = 16'd5;

  typedef struct packed {
    op_t        op;
    logic [7:0] wdata;
    logic       ack_out;
    logic [7:0] line_bits;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic [1:0] hold_units;
    logic       sample_point;
    logic       last;
    logic [7:0] rx_byte;
    logic       nack;
  } seg_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [4:0] last_step;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qhead_t;

endpackage

// ===== rtl/i2cms_front.sv =====
module i2cms_front
  import i2cms_pkg::*;
(
  input  logic  cmd_valid,
  output logic  cmd_ready,
  input  cmd_t  cmd,
  input  logic  q_full,
  output logic  push,
  output qent_t push_ent
);

  assign cmd_ready = !q_full;
  assign push      = cmd_valid && !q_full;

  // tag each command with the index of its final segment
  always_comb begin
    push_ent.cmd = cmd;
    case (cmd.op)
      OP_START, OP_STOP: push_ent.last_step = LAST_STEP_COND;
      OP_WRITE, OP_READ: push_ent.last_step = LAST_STEP_BYTE;
      default:           push_ent.last_step = LAST_STEP_COND;
    endcase
  end

endmodule

// ===== rtl/i2cms_queue.sv =====
module i2cms_queue
  import i2cms_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qent_t  push_ent,
  input  logic   pop,
  output logic   full,
  output qhead_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  qent_t         mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count, count_next;

  assign full       = (count == CNT_FULL);
  assign head.valid = (count != '0);
  assign head.ent   = mem[rptr];

  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + CW'(1);
      2'b01:   count_next = count - CW'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + PW'(1);
      end
    end
  end

endmodule

// ===== rtl/i2cms_back.sv =====
module i2cms_back
  import i2cms_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  qhead_t head,
  output logic   pop,
  output logic   seg_valid,
  input  logic   seg_ready,
  output seg_t   seg
);

  logic       scl, sda, oe;
  logic       scl_next, sda_next, oe_next, oe_keep;
  logic [4:0] step;
  logic [1:0] ph;
  logic [2:0] bi;
  logic       fire, lst, bitwin;
  logic [1:0] hold;
  logic       smp;
  qent_t      e;

  assign e    = head.ent;
  assign fire = head.valid && (!seg_valid || seg_ready);
  assign lst  = (step == e.last_step);
  assign pop  = fire && lst;

  always_comb begin
    scl_next = scl;
    sda_next = sda;
    oe_next  = oe;
    hold     = 2'd1;
    smp      = 1'b0;
    bitwin   = 1'b0;
    case (e.cmd.op)
      OP_START: begin
        case (step)
          5'd1: begin
            oe_next  = 1'b1;
            sda_next = 1'b1;
          end
          5'd2:    scl_next = 1'b1;
          5'd3:    sda_next = 1'b0;
          default: ;
        endcase
      end
      OP_STOP: begin
        case (step)
          5'd0: begin
            oe_next  = 1'b1;
            scl_next = 1'b0;
          end
          5'd1:    sda_next = 1'b0;
          5'd2:    scl_next = 1'b1;
          5'd3:    sda_next = 1'b1;
          default: ;
        endcase
      end
      OP_WRITE: begin
        if (step < WR_BITS_END) begin
          bitwin = 1'b1;
          case (ph)
            PH_LOW:  scl_next = 1'b0;
            PH_MID:  sda_next = e.cmd.wdata[bi];
            PH_HIGH: begin
              scl_next = 1'b1;
              hold     = 2'd2;
            end
            default: ;
          endcase
        end else begin
          case (step)
            WR_REL_SCL: scl_next = 1'b0;
            WR_REL_SDA: sda_next = 1'b1;
            WR_ACK_HI: begin
              oe_next  = 1'b0;
              scl_next = 1'b1;
            end
            WR_ACK_SMP: smp = 1'b1;
            LAST_STEP_BYTE: begin
              scl_next = 1'b0;
              hold     = 2'd2;
            end
            default: ;
          endcase
        end
      end
      OP_READ: begin
        if (step >= RD_BITS_BEG && step < RD_BITS_END) begin
          bitwin = 1'b1;
          case (ph)
            PH_LOW: begin
              oe_next  = 1'b0;
              scl_next = 1'b1;
            end
            PH_MID:  smp = 1'b1;
            PH_HIGH: begin
              scl_next = 1'b0;
              hold     = 2'd2;
            end
            default: ;
          endcase
        end else begin
          case (step)
            5'd0:        scl_next = 1'b0;
            5'd1:        sda_next = 1'b1;
            RD_BITS_END: begin
              oe_next  = 1'b1;
              scl_next = 1'b0;
            end
            RD_ACK_SDA:  sda_next = e.cmd.ack_out;
            RD_ACK_HI: begin
              scl_next = 1'b1;
              hold     = 2'd2;
            end
            LAST_STEP_BYTE: scl_next = 1'b0;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    // a write takes SDA back once its ack segment is out
    oe_keep = (e.cmd.op == OP_WRITE && lst) ? 1'b1 : oe_next;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      seg.scl_level    <= scl_next;
      seg.sda_level    <= sda_next;
      seg.sda_drive    <= oe_next;
      seg.hold_units   <= hold;
      seg.sample_point <= smp;
      seg.last         <= lst;
      seg.rx_byte      <= (e.cmd.op == OP_READ && lst) ? e.cmd.line_bits : 8'd0;
      seg.nack         <= (e.cmd.op == OP_WRITE && lst) ? e.cmd.line_bits[0] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
      scl       <= 1'b1;
      sda       <= 1'b1;
      oe        <= 1'b0;
      step      <= '0;
      ph        <= PH_LOW;
      bi        <= BIT_TOP;
    end else begin
      if (fire) begin
        seg_valid <= 1'b1;
      end else if (seg_ready) begin
        seg_valid <= 1'b0;
      end
      if (fire) begin
        scl <= scl_next;
        sda <= sda_next;
        oe  <= oe_keep;
        if (lst) begin
          step <= '0;
          ph   <= PH_LOW;
          bi   <= BIT_TOP;
        end else begin
          step <= step + 5'd1;
          if (bitwin) begin
            if (ph == PH_HIGH) begin
              ph <= PH_LOW;
              bi <= bi - 3'd1;
            end else begin
              ph <= ph + 2'd1;
            end
          end
        end
      end
    end
  end

endmodule

// ===== rtl/i2c_master_byte_sequencer.sv =====
// Path: a command beat is written into the queue, and its first segment is then
//   registered from the queue head into the segment output when the back end is idle.
// Throughput: one segment beat per cycle while seg_ready is high and a command is queued;
//   start and stop are 4 segments, write and read byte 30, as tagged by the front end.
// The queue holds QUEUE_DEPTH commands, the one in progress included; cmd_ready drops when full.
// Reset: SCL and SDA held released high, SDA undriven, queue empty, unit_delay = 5.
`include "assert_macros.svh"

module i2c_master_byte_sequencer
  import i2cms_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        seg_valid,
  input  logic        seg_ready,
  output seg_t        seg
);

  // Delay unit in clock cycles. Segment lengths leave the block in units;
  // the value is held here only and is not an output of the block.
  logic [15:0] unit_delay;

  logic   q_full;
  logic   push;
  logic   pop;
  qent_t  push_ent;
  qhead_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_delay <= UNIT_DELAY_RST;
    end else if (cfg_we) begin
      unit_delay <= cfg_data;
    end
  end

  // Front: take a command beat, tag it with the index of its final segment.
  i2cms_front u_front (
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .q_full    (q_full),
    .push      (push),
    .push_ent  (push_ent)
  );

  // Short queue: decouple command intake from segment output.
  i2cms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .full     (q_full),
    .head     (head)
  );

  // Back: advance one segment per cycle unless a held segment is not taken, keep pin
  // levels across commands, drop the queue head after its final segment.
  i2cms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg)
  );

  // SDA is released whenever the slave's level is sampled.
  `ASSERT_IMPL(a_sample_released, clk, rst, seg_valid && seg.sample_point, !seg.sda_drive, "sample with SDA driven")

  // Results appear only on the final beat of a command.
  `ASSERT_IMPL(a_result_on_last, clk, rst, seg_valid && !seg.last, seg.rx_byte == 8'd0 && !seg.nack, "result before last beat")

  // A full queue holds at least one command for the back end.
  `ASSERT_IMPL(a_full_has_head, clk, rst, !cmd_ready, head.valid, "queue full but empty head")

  // A beat that drops the queue head is a last segment.
  `ASSERT_NEXT(a_pop_marks_last, clk, rst, pop, seg_valid && seg.last, "pop without last beat")

  // A delay unit is at least one clock cycle.
  `ASSERT_IMPL(a_unit_delay_legal, clk, rst, 1'b1, unit_delay != 16'd0, "delay unit of zero cycles")

endmodule

// ===== bench/i2c_master_byte_sequencer_tb.sv =====
`timescale 1ns / 1ps

module i2c_master_byte_sequencer_tb
  import i2cms_pkg::*;
;

  localparam int STALL_LIMIT = 4000;  // cycles with no beat on either side
  localparam int HOLDOFF_CYCLES = 400;
  localparam int IDLE_PCT = 31;

  // Pin-segment predictor: tracks the registered pin levels across commands and
  // expands each accepted command into the run of segments it must produce.
  class seg_tracker;
    seg_t due_segs[$];
    seg_t cmd_segs[$];
    logic scl, sda, drv;
    logic [15:0] unit_delay;
    int errors;
    int segs_checked;
    int op_count[4];

    function new();
      scl = 1'b1;
      sda = 1'b1;
      drv = 1'b0;
      unit_delay = UNIT_DELAY_RST;
      errors = 0;
      segs_checked = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    // unit_delay only scales real time; segment beats carry units
    function void set_unit_delay(logic [15:0] v);
      unit_delay = v;
    endfunction

    function void emit_seg(logic [1:0] hold, logic smp);
      seg_t s;
      s = '0;
      s.scl_level = scl;
      s.sda_level = sda;
      s.sda_drive = drv;
      s.hold_units = hold;
      s.sample_point = smp;
      cmd_segs.push_back(s);
    endfunction

    function void drive_bit(logic b);
      scl = 1'b0;
      emit_seg(2'd1, 1'b0);
      sda = b;
      emit_seg(2'd1, 1'b0);
      scl = 1'b1;
      emit_seg(2'd2, 1'b0);
    endfunction

    function void strobe_bit();
      scl = 1'b1;
      emit_seg(2'd1, 1'b0);
      emit_seg(2'd1, 1'b1);
      scl = 1'b0;
      emit_seg(2'd2, 1'b0);
    endfunction

    function void free_sda();
      scl = 1'b0;
      emit_seg(2'd1, 1'b0);
      sda = 1'b1;
      emit_seg(2'd1, 1'b0);
    endfunction

    function void expand_cmd(cmd_t c);
      seg_t s;
      logic [7:0] shift;
      cmd_segs.delete();
      op_count[c.op]++;
      case (c.op)
        OP_START: begin
          // first segment keeps whatever the previous command left on the pins
          emit_seg(2'd1, 1'b0);
          drv = 1'b1;
          sda = 1'b1;
          emit_seg(2'd1, 1'b0);
          scl = 1'b1;
          emit_seg(2'd1, 1'b0);
          sda = 1'b0;
          emit_seg(2'd1, 1'b0);
        end
        OP_STOP: begin
          drv = 1'b1;
          scl = 1'b0;
          emit_seg(2'd1, 1'b0);
          sda = 1'b0;
          emit_seg(2'd1, 1'b0);
          scl = 1'b1;
          emit_seg(2'd1, 1'b0);
          sda = 1'b1;
          emit_seg(2'd1, 1'b0);
        end
        OP_WRITE: begin
          shift = c.wdata;
          for (int j = 0; j < BITS_PER_BYTE; j++) begin
            drive_bit(shift[7]);
            shift = shift << 1;
          end
          emit_seg(2'd1, 1'b0);
          free_sda();
          drv = 1'b0;
          strobe_bit();
          drv = 1'b1;
        end
        default: begin
          free_sda();
          drv = 1'b0;
          for (int j = 0; j < BITS_PER_BYTE; j++) strobe_bit();
          drv = 1'b1;
          drive_bit(c.ack_out);
          scl = 1'b0;
          emit_seg(2'd1, 1'b0);
        end
      endcase
      s = cmd_segs.pop_back();
      s.last = 1'b1;
      if (c.op == OP_WRITE) s.nack = c.line_bits[0];
      if (c.op == OP_READ) s.rx_byte = c.line_bits;
      cmd_segs.push_back(s);
      foreach (cmd_segs[i]) due_segs.push_back(cmd_segs[i]);
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: segment %0d field %s mismatch: expected %0h, actual %0h",
                 $time, segs_checked, name, want, got);
        errors++;
      end
    endfunction

    function void compare_seg(seg_t got);
      seg_t want;
      if (due_segs.size() == 0) begin
        $display("%0t: unexpected segment beat: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = due_segs.pop_front();
      field_check("scl_level", 8'(want.scl_level), 8'(got.scl_level));
      field_check("sda_level", 8'(want.sda_level), 8'(got.sda_level));
      field_check("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
      field_check("hold_units", 8'(want.hold_units), 8'(got.hold_units));
      field_check("sample_point", 8'(want.sample_point), 8'(got.sample_point));
      field_check("last", 8'(want.last), 8'(got.last));
      field_check("rx_byte", want.rx_byte, got.rx_byte);
      field_check("nack", 8'(want.nack), 8'(got.nack));
      segs_checked++;
    endfunction

    function int pending();
      return due_segs.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic seg_valid;
  logic seg_ready = 1'b0;
  seg_t seg;

  seg_tracker sb = new();
  int sent = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  bit no_idle = 1'b0;

  i2c_master_byte_sequencer uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .seg_valid(seg_valid),
    .seg_ready(seg_ready),
    .seg(seg)
  );

  always #5 clk = ~clk;

  // Segment receiver: drop ready at random, hold off once for a long stretch on
  // request, and outside the hold-off stay ready when idling is switched off.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLDOFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      seg_ready <= 1'b0;
    end else if (no_idle || rst) begin
      seg_ready <= !rst;
    end else begin
      seg_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Check every segment beat at the edge it lands on; the watchdog counts
  // edges with no beat on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if (seg_valid && seg_ready) sb.compare_seg(seg);
      if ((seg_valid && seg_ready) || (cmd_valid && cmd_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no beat for %0d cycles, %0d segments still due",
                   $time, stall_cycles, sb.pending());
          $display("i2c_master_byte_sequencer_tb: done, errors");
          $finish;
        end
      end
    end
  end

  function automatic cmd_t make_cmd(op_t op, logic [7:0] wd, logic ack, logic [7:0] line);
    cmd_t c;
    c.op = op;
    c.wdata = wd;
    c.ack_out = ack;
    c.line_bits = line;
    return c;
  endfunction

  function automatic cmd_t rand_cmd(op_t op);
    return make_cmd(op, 8'($urandom), 1'($urandom), 8'($urandom));
  endfunction

  // Offer one command beat; hold valid and payload until accepted.
  task automatic send_cmd(input cmd_t c);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sb.expand_cmd(c);
    sent++;
  endtask

  // Pause the sender until every predicted segment has come out.
  task automatic drain_all();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_unit_delay(input logic [15:0] v);
    drain_all();
    // let the sequencer settle past the last segment before touching config
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_unit_delay(v);
  endtask

  // Well-formed transfer: start, address byte, zero to four data bytes, usually a stop
  // (otherwise the next transfer begins with a repeated start).
  task automatic send_transfer();
    int n;
    n = $urandom_range(4);
    send_cmd(rand_cmd(OP_START));
    send_cmd(rand_cmd(OP_WRITE));
    for (int k = 0; k < n; k++) begin
      send_cmd(rand_cmd(op_t'($urandom_range(1) ? OP_WRITE : OP_READ)));
    end
    if ($urandom_range(9) != 0) send_cmd(rand_cmd(OP_STOP));
  endtask

  // Mostly transfers, the rest stray commands in any order.
  task automatic run_traffic(input int count);
    int target;
    target = sent + count;
    while (sent < target) begin
      if ($urandom_range(99) < 75) send_transfer();
      else send_cmd(rand_cmd(op_t'($urandom_range(3))));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_unit_delay(16'hFFFF);

    // Directed: read straight out of reset (SDA still undriven), starts after every
    // kind of command but a stop, data and ack extremes, writes without a start.
    send_cmd(make_cmd(OP_READ, 8'h00, 1'b1, 8'hA5));
    send_cmd(make_cmd(OP_START, 8'hFF, 1'b0, 8'h00));
    send_cmd(make_cmd(OP_WRITE, 8'h00, 1'b0, 8'h00));
    send_cmd(make_cmd(OP_WRITE, 8'hFF, 1'b1, 8'h01));
    send_cmd(make_cmd(OP_WRITE, 8'h80, 1'b0, 8'hFE));
    send_cmd(make_cmd(OP_WRITE, 8'h01, 1'b1, 8'hFF));
    send_cmd(make_cmd(OP_READ, 8'hFF, 1'b0, 8'hFF));
    send_cmd(make_cmd(OP_READ, 8'h00, 1'b1, 8'h00));
    send_cmd(make_cmd(OP_START, 8'h00, 1'b1, 8'hFF));
    send_cmd(make_cmd(OP_READ, 8'h55, 1'b1, 8'h5A));
    send_cmd(make_cmd(OP_STOP, 8'h00, 1'b0, 8'h00));
    send_cmd(make_cmd(OP_STOP, 8'hFF, 1'b1, 8'hFF));
    send_cmd(make_cmd(OP_WRITE, 8'h7F, 1'b0, 8'hFF));
    send_cmd(make_cmd(OP_START, 8'hAA, 1'b0, 8'h55));
    send_cmd(make_cmd(OP_START, 8'h55, 1'b1, 8'hAA));
    send_cmd(make_cmd(OP_STOP, 8'h00, 1'b0, 8'h00));
    send_cmd(make_cmd(OP_READ, 8'h00, 1'b0, 8'h80));
    send_cmd(make_cmd(OP_START, 8'h00, 1'b0, 8'h00));
    send_cmd(make_cmd(OP_WRITE, 8'hA5, 1'b0, 8'h01));
    send_cmd(make_cmd(OP_STOP, 8'h00, 1'b0, 8'h00));

    // Random traffic at the shortest delay unit.
    set_unit_delay(16'h0001);
    run_traffic(110);

    // No idling on either side, then a long receiver hold-off while commands
    // keep coming so the queue fills and input stalls.
    set_unit_delay(16'($urandom_range(2, 65534)));
    no_idle = 1'b1;
    run_traffic(30);
    hold_req = 1'b1;
    run_traffic(40);
    no_idle = 1'b0;

    // Random traffic with a full sender pause halfway through.
    set_unit_delay(UNIT_DELAY_RST);
    run_traffic(60);
    drain_all();
    run_traffic(60);

    set_unit_delay(16'($urandom_range(2, 65534)));
    run_traffic(50);

    drain_all();
    repeat (20) @(posedge clk);

    if (sb.pending() != 0) begin
      $display("%0t: segments left over: expected 0, actual %0d", $time, sb.pending());
      sb.errors++;
    end
    $display("Sent %0d commands (start %0d, stop %0d, write %0d, read %0d), %0d segments",
             sent, sb.op_count[OP_START], sb.op_count[OP_STOP], sb.op_count[OP_WRITE],
             sb.op_count[OP_READ], sb.segs_checked);
    $display("checked under unit_delay 1, 5, 65535 and random, with stalls and a hold-off.");
    if (sb.errors == 0) begin
      $display("i2c_master_byte_sequencer_tb: done, clean");
    end else begin
      $display("i2c_master_byte_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule
